[design/ltsp_pkg.sv]
package ltsp_pkg;

    // Default build values
    localparam int HASH_BYTES_DEF = 32;
    localparam int COUNT_BITS_DEF = 32;

    // Fixed field sizes in bytes
    localparam int VERSION_BYTES  = 4;
    localparam int INDEX_BYTES    = 4;
    localparam int SEQNO_BYTES    = 4;
    localparam int VALUE_BYTES    = 8;
    localparam int LOCKTIME_BYTES = 4;

    localparam int SCRIPT_LEN_W = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;

    // Event codes
    localparam logic [4:0] EV_VERSION     = 5'd0;
    localparam logic [4:0] EV_IN_COUNT    = 5'd1;
    localparam logic [4:0] EV_HASH_START  = 5'd2;
    localparam logic [4:0] EV_HASH_BYTE   = 5'd3;
    localparam logic [4:0] EV_HASH_END    = 5'd4;
    localparam logic [4:0] EV_INDEX       = 5'd5;
    localparam logic [4:0] EV_IN_SLEN     = 5'd6;
    localparam logic [4:0] EV_IN_SBYTE    = 5'd7;
    localparam logic [4:0] EV_SEQUENCE    = 5'd8;
    localparam logic [4:0] EV_OUT_COUNT   = 5'd9;
    localparam logic [4:0] EV_OUT_VALUE   = 5'd10;
    localparam logic [4:0] EV_OUT_SLEN    = 5'd11;
    localparam logic [4:0] EV_OUT_SBYTE   = 5'd12;
    localparam logic [4:0] EV_LOCKTIME    = 5'd13;
    localparam logic [4:0] EV_UNSUPPORTED = 5'd14;
    localparam logic [4:0] EV_INVALID     = 5'd15;
    localparam logic [4:0] EV_REJECTED    = 5'd16;

    // All results caused by one byte; at most one of them carries a value
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][4:0] codes;
        logic [63:0]     value;
    } t_bundle;

    function automatic logic carries_value(input logic [4:0] code);
        return !(code == EV_HASH_START || code == EV_HASH_END ||
                 code == EV_UNSUPPORTED || code == EV_INVALID ||
                 code == EV_REJECTED);
    endfunction

endpackage

[design/ltsp_front.sv]
module ltsp_front
    import ltsp_pkg::*;
#(
    parameter int HASH_BYTES = HASH_BYTES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [7:0]  i_data_byte,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_bundle     o_bundle
);

    localparam int OffW = (HASH_BYTES > 8) ? $clog2(HASH_BYTES) : 3;
    localparam logic [OffW:0] HashLast = (OffW + 1)'(HASH_BYTES);
    localparam logic [32:0] CountMax = (33'd1 << COUNT_BITS) - 33'd1;

    localparam logic [2:0] VerLast   = 3'(VERSION_BYTES - 1);
    localparam logic [2:0] IdxLast   = 3'(INDEX_BYTES - 1);
    localparam logic [2:0] SeqLast   = 3'(SEQNO_BYTES - 1);
    localparam logic [2:0] ValLast   = 3'(VALUE_BYTES - 1);
    localparam logic [2:0] LockLast  = 3'(LOCKTIME_BYTES - 1);

    localparam logic [3:0] PH_VERSION    = 4'd0;
    localparam logic [3:0] PH_VIN_COUNT  = 4'd1;
    localparam logic [3:0] PH_VIN_HASH   = 4'd2;
    localparam logic [3:0] PH_VIN_INDEX  = 4'd3;
    localparam logic [3:0] PH_VIN_SLEN   = 4'd4;
    localparam logic [3:0] PH_VIN_SCRIPT = 4'd5;
    localparam logic [3:0] PH_VIN_SEQNO  = 4'd6;
    localparam logic [3:0] PH_VOUT_COUNT = 4'd7;
    localparam logic [3:0] PH_VOUT_VALUE = 4'd8;
    localparam logic [3:0] PH_VOUT_SLEN  = 4'd9;
    localparam logic [3:0] PH_VOUT_SCRIPT = 4'd10;
    localparam logic [3:0] PH_LOCKTIME   = 4'd11;
    localparam logic [3:0] PH_DONE       = 4'd12;
    localparam logic [3:0] PH_ERROR      = 4'd13;

    localparam logic [7:0] CS_PREFIX_16 = 8'hfd;
    localparam logic [7:0] CS_PREFIX_32 = 8'hfe;
    localparam logic [7:0] CS_PREFIX_64 = 8'hff;

    logic [3:0]              r_phase, n_phase;
    logic [OffW-1:0]         r_off, n_off;
    logic [63:0]             r_asm, n_asm;
    logic [2:0]              r_vleft, n_vleft;
    logic [COUNT_BITS-1:0]   r_total, n_total;
    logic [COUNT_BITS-1:0]   r_done, n_done;
    logic [SCRIPT_LEN_W-1:0] r_sleft, n_sleft;

    logic                    accept;
    logic [63:0]             asm_new;
    logic                    cd_fire;
    logic [31:0]             cd_v;
    logic [COUNT_BITS-1:0]   done_inc;
    logic [SCRIPT_LEN_W-1:0] sleft_dec;
    t_bundle                 bnd;

    function automatic logic [63:0] put_lane(input logic [63:0] a, input logic [2:0] k,
                                             input logic [7:0] b);
        logic [63:0] r;
        r = a;
        r[k*8 +: 8] = a[k*8 +: 8] | b;
        return r;
    endfunction

    assign accept    = i_push && !i_q_full;
    assign done_inc  = r_done + COUNT_BITS'(1);
    assign sleft_dec = r_sleft - SCRIPT_LEN_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_off   = r_off;
        n_asm   = r_asm;
        n_vleft = r_vleft;
        n_total = r_total;
        n_done  = r_done;
        n_sleft = r_sleft;
        bnd     = '0;
        cd_fire = 1'b0;
        cd_v    = '0;
        asm_new = put_lane(r_asm, r_off[2:0], i_data_byte);

        unique case (r_phase)
            PH_VERSION, PH_VIN_INDEX, PH_VIN_SEQNO, PH_VOUT_VALUE, PH_LOCKTIME: begin
                // Assemble a fixed-size little-endian field
                priority if (r_phase == PH_VERSION && r_off[2:0] == VerLast) begin
                    bnd.codes[0] = EV_VERSION;
                    bnd.cnt = 2'd1;
                    bnd.value = asm_new;
                    n_phase = PH_VIN_COUNT;
                    n_off = '0;
                    n_asm = '0;
                    n_vleft = '0;
                end else if (r_phase == PH_VIN_INDEX && r_off[2:0] == IdxLast) begin
                    bnd.codes[0] = EV_INDEX;
                    bnd.cnt = 2'd1;
                    bnd.value = asm_new;
                    n_phase = PH_VIN_SLEN;
                    n_off = '0;
                    n_asm = '0;
                    n_vleft = '0;
                end else if (r_phase == PH_VIN_SEQNO && r_off[2:0] == SeqLast) begin
                    bnd.codes[0] = EV_SEQUENCE;
                    bnd.cnt = 2'd1;
                    bnd.value = asm_new;
                    n_done = done_inc;
                    n_phase = (done_inc == r_total) ? PH_VOUT_COUNT : PH_VIN_HASH;
                    n_off = '0;
                    n_asm = '0;
                    n_vleft = '0;
                end else if (r_phase == PH_VOUT_VALUE && r_off[2:0] == ValLast) begin
                    bnd.codes[0] = EV_OUT_VALUE;
                    bnd.cnt = 2'd1;
                    bnd.value = asm_new;
                    n_phase = PH_VOUT_SLEN;
                    n_off = '0;
                    n_asm = '0;
                    n_vleft = '0;
                end else if (r_phase == PH_LOCKTIME && r_off[2:0] == LockLast) begin
                    bnd.codes[0] = EV_LOCKTIME;
                    bnd.cnt = 2'd1;
                    bnd.value = asm_new;
                    n_phase = PH_DONE;
                    n_off = '0;
                    n_asm = '0;
                    n_vleft = '0;
                end else begin
                    n_asm = asm_new;
                    n_off = r_off + OffW'(1);
                end
            end
            PH_VIN_COUNT, PH_VIN_SLEN, PH_VOUT_COUNT, PH_VOUT_SLEN: begin
                if (r_vleft == 3'd0) begin
                    priority if (i_data_byte < CS_PREFIX_16) begin
                        cd_fire = 1'b1;
                        cd_v = {24'd0, i_data_byte};
                    end else if (i_data_byte == CS_PREFIX_64) begin
                        bnd.codes[0] = EV_UNSUPPORTED;
                        bnd.cnt = 2'd1;
                        n_phase = PH_ERROR;
                        n_off = '0;
                        n_asm = '0;
                        n_vleft = '0;
                    end else begin
                        n_vleft = (i_data_byte == CS_PREFIX_32) ? 3'd4 : 3'd2;
                        n_off = '0;
                        n_asm = '0;
                    end
                end else begin
                    n_asm = put_lane(r_asm, {1'b0, r_off[1:0]}, i_data_byte);
                    n_off = r_off + OffW'(1);
                    n_vleft = r_vleft - 3'd1;
                    if (r_vleft == 3'd1) begin
                        cd_fire = 1'b1;
                        cd_v = n_asm[31:0];
                    end
                end
            end
            PH_VIN_HASH: begin
                if (r_off == '0) begin
                    bnd.codes[bnd.cnt] = EV_HASH_START;
                    bnd.cnt = bnd.cnt + 2'd1;
                end
                bnd.codes[bnd.cnt] = EV_HASH_BYTE;
                bnd.cnt = bnd.cnt + 2'd1;
                bnd.value = {56'd0, i_data_byte};
                if ({1'b0, r_off} + (OffW + 1)'(1) >= HashLast) begin
                    bnd.codes[bnd.cnt] = EV_HASH_END;
                    bnd.cnt = bnd.cnt + 2'd1;
                    n_phase = PH_VIN_INDEX;
                    n_off = '0;
                    n_asm = '0;
                    n_vleft = '0;
                end else begin
                    n_off = r_off + OffW'(1);
                end
            end
            PH_VIN_SCRIPT, PH_VOUT_SCRIPT: begin
                bnd.codes[0] = (r_phase == PH_VIN_SCRIPT) ? EV_IN_SBYTE : EV_OUT_SBYTE;
                bnd.cnt = 2'd1;
                bnd.value = {56'd0, i_data_byte};
                n_sleft = sleft_dec;
                if (sleft_dec == '0) begin
                    n_off = '0;
                    n_asm = '0;
                    n_vleft = '0;
                    if (r_phase == PH_VIN_SCRIPT) begin
                        n_phase = PH_VIN_SEQNO;
                    end else begin
                        n_done = done_inc;
                        n_phase = (done_inc == r_total) ? PH_LOCKTIME : PH_VOUT_VALUE;
                    end
                end
            end
            default: begin
                // Done or error: drop the byte
                bnd.codes[0] = EV_REJECTED;
                bnd.cnt = 2'd1;
            end
        endcase

        // Finished CompactSize: act on the phase it belongs to
        if (cd_fire) begin
            n_off = '0;
            n_asm = '0;
            n_vleft = '0;
            bnd.cnt = 2'd1;
            bnd.value = {32'd0, cd_v};
            priority if (r_phase == PH_VIN_COUNT || r_phase == PH_VOUT_COUNT) begin
                if (cd_v == '0 || {1'b0, cd_v} > CountMax) begin
                    bnd.codes[0] = EV_INVALID;
                    n_phase = PH_ERROR;
                end else begin
                    bnd.codes[0] = (r_phase == PH_VIN_COUNT) ? EV_IN_COUNT : EV_OUT_COUNT;
                    n_total = cd_v[COUNT_BITS-1:0];
                    n_done = '0;
                    n_phase = (r_phase == PH_VIN_COUNT) ? PH_VIN_HASH : PH_VOUT_VALUE;
                end
            end else if (r_phase == PH_VIN_SLEN) begin
                bnd.codes[0] = EV_IN_SLEN;
                n_sleft = cd_v;
                n_phase = (cd_v == '0) ? PH_VIN_SEQNO : PH_VIN_SCRIPT;
            end else begin
                bnd.codes[0] = EV_OUT_SLEN;
                n_sleft = cd_v;
                if (cd_v == '0) begin
                    n_done = done_inc;
                    n_phase = (done_inc == r_total) ? PH_LOCKTIME : PH_VOUT_VALUE;
                end else begin
                    n_phase = PH_VOUT_SCRIPT;
                end
            end
        end
    end

    assign o_q_push = accept && (bnd.cnt != 2'd0);
    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_VERSION;
            r_off   <= '0;
            r_asm   <= '0;
            r_vleft <= '0;
            r_total <= '0;
            r_done  <= '0;
            r_sleft <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_off   <= n_off;
            r_asm   <= n_asm;
            r_vleft <= n_vleft;
            r_total <= n_total;
            r_done  <= n_done;
            r_sleft <= n_sleft;
        end
    end

endmodule

[design/ltsp_queue.sv]
module ltsp_queue
    import ltsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_bundle o_head
);

    t_bundle           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? r_wr + QPTR_W'(1) : r_wr;
        n_rd  = do_pop ? r_rd + QPTR_W'(1) : r_rd;
        n_cnt = r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[design/ltsp_back.sv]
module ltsp_back
    import ltsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_bundle     i_head,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [4:0]  o_event_code,
    output logic [63:0] o_field_value,
    output logic        o_last_of_run
);

    logic        r_valid, n_valid;
    logic [1:0]  r_idx, n_idx;
    logic [4:0]  r_code, n_code;
    logic [63:0] r_value, n_value;
    logic        r_last, n_last;
    logic        load;
    logic        take;

    assign load = !r_valid || i_pop;
    assign take = load && !i_q_empty;

    always_comb begin
        n_code  = i_head.codes[r_idx];
        n_value = carries_value(n_code) ? i_head.value : 64'd0;
        n_last  = (r_idx == i_head.cnt - 2'd1);
        n_valid = load ? !i_q_empty : r_valid;
        n_idx   = r_idx;
        if (take) begin
            n_idx = n_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    // Release the bundle once its last word moves to the output register
    assign o_q_pop = take && n_last;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_code  <= n_code;
            r_value <= n_value;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    assign o_empty       = !r_valid;
    assign o_event_code  = r_code;
    assign o_field_value = r_value;
    assign o_last_of_run = r_last;

endmodule

[design/legacy_tx_stream_parser_unit.sv]
// Streaming parser for a serialized legacy transaction, one byte per word.
// Input side is a queue write port: drive i_data_byte and raise push; the
// byte is taken at a clock edge where push is high and full is low.
// Result side is a queue read port: while empty is low the oldest event sits
// on o_event_code / o_field_value / o_last_of_run; pop takes it.
// A byte may cause zero to three events; o_last_of_run marks the final one.
// A byte's first event passes through the queue and then the output register
// before it shows on the result ports, when nothing is queued ahead of it.
// Throughput: one byte per cycle while full is low and each byte yields at most
// one event; the result port moves one event per cycle while pop is high, so
// bytes that yield two or three events (hash start and end) leave it one at a time.
// The classifier and the event sequencer are parted by a four-bundle queue.
// When the receiver stalls, events build up in the output register and the
// queue; full rises once the queue holds four bundles, and no event is lost.
// Reset (i_rst_n low at an edge) returns the parser to the version field and
// empties the queue and the output register.
module legacy_tx_stream_parser_unit
    import ltsp_pkg::*;
#(
    parameter int HASH_BYTES = HASH_BYTES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_event_code,
    output logic [63:0] o_field_value,
    output logic        o_last_of_run
);

    t_bundle q_in_bundle;
    t_bundle q_head;
    logic    q_push;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;

    // Front: walk the fields and classify each byte into an event bundle
    ltsp_front #(
        .HASH_BYTES (HASH_BYTES),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_bundle    (q_in_bundle)
    );

    // Hold bundles so the parser keeps taking bytes while the output stalls
    ltsp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (q_in_bundle),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_empty  (q_empty),
        .o_head   (q_head)
    );

    // Back: advance through each bundle one event per word
    ltsp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_head        (q_head),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_event_code  (o_event_code),
        .o_field_value (o_field_value),
        .o_last_of_run (o_last_of_run)
    );

    assign full = q_full;

endmodule
